/* design/pis_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pis_pkg
// shared types and constants of the power iteration spectral radius block
// ----------------------------------------------------------------------------
package pis_pkg;

   localparam int MAX_SIZE_DEFAULT = 64;

   localparam int CMD_W    = 2;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int SIZE_W   = 7;
   localparam int ITER_W   = 16;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 16;
   localparam int ITER_RESET = 16;
   localparam int SIZE_RESET = 64;

   localparam int DIVIDEND_W = 48;
   localparam int RADICAND_W = 64;

   localparam logic [CMD_W-1:0] CMD_LOAD_MATRIX = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD_VECTOR = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RUN         = 2'd2;
   localparam logic [CMD_W-1:0] CMD_UNUSED      = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_SATURATED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_ZERO_VEC  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_SIZE_IN_USE     = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_ITERATION_COUNT = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQ_RD,
      ST_SQ_MUL,
      ST_SQ_ACC,
      ST_ROOT,
      ST_ROOT_WAIT,
      ST_DV_RD,
      ST_DV_GO,
      ST_DV_WAIT,
      ST_MV_RD,
      ST_MV_MUL,
      ST_MV_ACC,
      ST_MV_WR,
      ST_CP_RD,
      ST_CP_WR,
      ST_FINISH
   } state_type;

endpackage

/* design/pis_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pis request and response channels
// valid / ready channels carrying commands in and radius estimates out
// ----------------------------------------------------------------------------
interface pis_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         cmd;
   logic signed [31:0] value;

   modport source (output valid, output cmd, output value, input ready);
   modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface pis_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] radius;
   logic [1:0]  status;

   modport source (output valid, output radius, output status, input ready);
   modport sink   (input valid, input radius, input status, output ready);
endinterface

/* design/pis_mul.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pis_mul
// shared signed 32x32 multiplier with registered product
// ----------------------------------------------------------------------------
module pis_mul (
   input  logic                clock,
   input  logic signed [31:0]  a,
   input  logic signed [31:0]  b,
   output logic signed [63:0]  product
);
   logic signed [63:0] product_ff;
   logic signed [63:0] product_in;

   assign product_in = 64'(a) * 64'(b);

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;
endmodule

/* design/pis_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pis_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module pis_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          done,
   input  logic [pis_pkg::DIVIDEND_W-1:0] dividend,
   input  logic [31:0]                   divisor,
   output logic [pis_pkg::DIVIDEND_W-1:0] quotient
);
   import pis_pkg::*;

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic [32:0]           rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [32:0]           rem_sh;

   always_comb begin
      rem_sh  = {rem_ff[31:0], quo_ff[DIVIDEND_W-1]};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         cnt_in  = CNT_W'(DIVIDEND_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, divisor}) begin
            rem_in = rem_sh - {1'b0, divisor};
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

/* design/pis_sqrt.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pis_sqrt
// digit by digit floor square root of a 64-bit value, one result bit per cycle
// ----------------------------------------------------------------------------
module pis_sqrt (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           done,
   input  logic [pis_pkg::RADICAND_W-1:0] radicand,
   output logic [31:0]                    root
);
   import pis_pkg::*;

   localparam int STEPS = RADICAND_W / 2;
   localparam int CNT_W = $clog2(STEPS + 1);

   logic [RADICAND_W-1:0] v_ff, v_in;
   logic [RADICAND_W-1:0] r_ff, r_in;
   logic [RADICAND_W-1:0] bit_ff, bit_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [RADICAND_W-1:0] trial;

   always_comb begin
      trial   = r_ff + bit_ff;
      v_in    = v_ff;
      r_in    = r_ff;
      bit_in  = bit_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         v_in    = radicand;
         r_in    = '0;
         bit_in  = RADICAND_W'(1) << (RADICAND_W - 2);
         cnt_in  = CNT_W'(STEPS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (v_ff >= trial) begin
            v_in = v_ff - trial;
            r_in = (r_ff >> 1) + bit_ff;
         end else begin
            r_in = r_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      v_ff   <= v_in;
      r_ff   <= r_in;
      bit_ff <= bit_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign root = r_ff[31:0];
endmodule

/* design/power_iteration_spectral_radius.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// power_iteration_spectral_radius
// power method estimate of the dominant eigenvalue magnitude, q16.16
// ----------------------------------------------------------------------------
// load transfers (matrix or vector element) are taken back to back while idle
// each pass of a run squares and sums the vector, takes the square root of
// the norm, normalizes each element with the serial divider, multiplies by
// the matrix with a multiply-accumulate per element and copies the result back
// the result register frees the request side once the estimate is stored
// synchronous active-high reset: n = 64, 16 passes, load indices cleared;
// stores are not cleared and hold garbage until written
// ----------------------------------------------------------------------------
module power_iteration_spectral_radius #(
   parameter int MAX_SIZE = pis_pkg::MAX_SIZE_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   pis_req_if.sink                          req_if,
   pis_rsp_if.source                        rsp_if,
   input  logic                             csr_we,
   input  logic [pis_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [pis_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import pis_pkg::*;

   // address widths of the stores
   localparam int MAT_DEPTH = MAX_SIZE * MAX_SIZE;
   localparam int MAW  = (MAX_SIZE > 1) ? $clog2(MAT_DEPTH) : 1;
   localparam int VAW  = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
   localparam int CNTW = VAW + 1;
   localparam int CW   = MAW + 1;
   localparam int N_RESET = (MAX_SIZE < SIZE_RESET) ? MAX_SIZE : SIZE_RESET;

   // stores
   logic signed [DATA_W-1:0] mat_mem [MAT_DEPTH];
   logic signed [DATA_W-1:0] vec_mem [MAX_SIZE];
   logic signed [DATA_W-1:0] prd_mem [MAX_SIZE];
   logic signed [DATA_W-1:0] mat_rd_ff, vec_rd_ff, prd_rd_ff;

   // sequencer and datapath registers
   state_type state_ff, state_in;
   logic [SIZE_W-1:0]   n_ff;
   logic [CW-1:0]       nsq_ff;
   logic [ITER_W-1:0]   iters_ff;
   logic [MAW-1:0]      mli_ff;
   logic [VAW-1:0]      vli_ff;
   logic [CNTW-1:0]     j_ff, i_ff;
   logic [MAW-1:0]      maddr_ff;
   logic [ITER_W-1:0]   iter_ff;
   logic [63:0]         sum_ff;
   logic signed [63:0]  acc_ff;
   logic [31:0]         nrm_ff;
   logic                neg_ff;
   logic                sat_ff;
   logic [31:0]         res_radius_ff;
   logic [STATUS_W-1:0] res_status_ff;
   logic                rsp_valid_ff;
   logic [31:0]         rsp_radius_ff;
   logic [STATUS_W-1:0] rsp_status_ff;

   // control
   logic                     req_xfer;
   logic                     vec_we, mat_we, prd_we;
   logic [VAW-1:0]           vec_waddr;
   logic signed [DATA_W-1:0] vec_wdata, prd_wdata;
   logic signed [DATA_W-1:0] mul_a;
   logic signed [63:0]       product;
   logic [DIVIDEND_W-1:0]    quotient;
   logic [31:0]              root;
   logic                     div_start, div_done;
   logic                     sqrt_start, sqrt_done;
   logic                     last_j, last_i, last_root;
   logic [CNTW-1:0]          n_cnt;
   logic [SIZE_W-1:0]        size_wr;
   logic [64:0]              sum_wide;
   logic signed [63:0]       acc_adj;
   logic signed [47:0]       row_q;
   logic                     row_fit;
   logic [31:0]              vec_mag;
   logic [31:0]              div_res;
   logic                     out_free;

   assign req_xfer = req_if.valid && req_if.ready;
   assign n_cnt    = CNTW'(n_ff);
   assign last_j   = (j_ff == n_cnt - CNTW'(1));
   assign last_i   = (i_ff == n_cnt - CNTW'(1));
   assign last_root = (iter_ff == iters_ff);
   assign out_free = !rsp_valid_ff || rsp_if.ready;

   // saturating sum of squares
   assign sum_wide = {1'b0, sum_ff} + {1'b0, product};

   // row sum / 65536 toward zero, then fit to 32 bits
   assign acc_adj = acc_ff[63] ? acc_ff + 64'sd65535 : acc_ff;
   assign row_q   = 48'(acc_adj >>> 16);
   assign row_fit = (row_q[47:31] == '0) || (row_q[47:31] == '1);
   assign prd_wdata = row_fit ? row_q[31:0]
                              : (row_q[47] ? 32'sh80000000 : 32'sh7FFFFFFF);

   // normalize: |x| * 65536 / norm, sign put back
   assign vec_mag = vec_rd_ff[31] ? 32'(-vec_rd_ff) : 32'(vec_rd_ff);
   assign div_res = neg_ff ? 32'(-quotient[31:0]) : quotient[31:0];

   // size write clamps to 1..MAX_SIZE
   always_comb begin
      size_wr = csr_wdata[SIZE_W-1:0];
      if (size_wr == '0) begin
         size_wr = SIZE_W'(1);
      end
      if (32'(size_wr) > MAX_SIZE) begin
         size_wr = SIZE_W'(MAX_SIZE);
      end
   end

   // shared units
   assign mul_a = (state_ff == ST_MV_MUL) ? mat_rd_ff : vec_rd_ff;

   pis_mul u_mul (
      .clock   (clock),
      .a       (mul_a),
      .b       (vec_rd_ff),
      .product (product)
   );

   pis_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .done     (div_done),
      .dividend ({vec_mag, 16'h0000}),
      .divisor  (nrm_ff),
      .quotient (quotient)
   );

   pis_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .done     (sqrt_done),
      .radicand (sum_ff),
      .root     (root)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer && req_if.cmd == CMD_RUN) begin
               state_in = ST_SQ_RD;
            end
         end
         ST_SQ_RD:  state_in = ST_SQ_MUL;
         ST_SQ_MUL: state_in = ST_SQ_ACC;
         ST_SQ_ACC: state_in = last_j ? ST_ROOT : ST_SQ_RD;
         ST_ROOT:   state_in = ST_ROOT_WAIT;
         ST_ROOT_WAIT: begin
            if (sqrt_done) begin
               state_in = (root == '0 || last_root) ? ST_FINISH : ST_DV_RD;
            end
         end
         ST_DV_RD:  state_in = ST_DV_GO;
         ST_DV_GO:  state_in = ST_DV_WAIT;
         ST_DV_WAIT: begin
            if (div_done) begin
               state_in = last_j ? ST_MV_RD : ST_DV_RD;
            end
         end
         ST_MV_RD:  state_in = ST_MV_MUL;
         ST_MV_MUL: state_in = ST_MV_ACC;
         ST_MV_ACC: state_in = last_j ? ST_MV_WR : ST_MV_RD;
         ST_MV_WR:  state_in = last_i ? ST_CP_RD : ST_MV_RD;
         ST_CP_RD:  state_in = ST_CP_WR;
         ST_CP_WR:  state_in = last_j ? ST_SQ_RD : ST_CP_RD;
         ST_FINISH: state_in = out_free ? ST_IDLE : ST_FINISH;
         default:   state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_if.ready = 1'b0;
      vec_we       = 1'b0;
      vec_waddr    = j_ff[VAW-1:0];
      vec_wdata    = prd_rd_ff;
      mat_we       = 1'b0;
      prd_we       = 1'b0;
      div_start    = 1'b0;
      sqrt_start   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_if.ready = 1'b1;
            if (req_xfer && req_if.cmd == CMD_LOAD_MATRIX) begin
               mat_we = 1'b1;
            end
            if (req_xfer && req_if.cmd == CMD_LOAD_VECTOR) begin
               vec_we    = 1'b1;
               vec_waddr = vli_ff;
               vec_wdata = req_if.value;
            end
         end
         ST_ROOT:  sqrt_start = 1'b1;
         ST_DV_GO: div_start = 1'b1;
         ST_DV_WAIT: begin
            vec_we    = div_done;
            vec_wdata = div_res;
         end
         ST_MV_WR: prd_we = 1'b1;
         ST_CP_WR: vec_we = 1'b1;
         default: begin
         end
      endcase
   end

   // stores, read every cycle
   always_ff @(posedge clock) begin
      if (mat_we) begin
         mat_mem[mli_ff] <= req_if.value;
      end
      if (vec_we) begin
         vec_mem[vec_waddr] <= vec_wdata;
      end
      if (prd_we) begin
         prd_mem[i_ff[VAW-1:0]] <= prd_wdata;
      end
      mat_rd_ff <= mat_mem[maddr_ff];
      vec_rd_ff <= vec_mem[j_ff[VAW-1:0]];
      prd_rd_ff <= prd_mem[j_ff[VAW-1:0]];
   end

   // datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         n_ff         <= SIZE_W'(N_RESET);
         nsq_ff       <= CW'(N_RESET * N_RESET);
         iters_ff     <= ITER_W'(ITER_RESET);
         mli_ff       <= '0;
         vli_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;

         if (csr_we && csr_index == REG_SIZE_IN_USE) begin
            n_ff   <= size_wr;
            nsq_ff <= CW'(size_wr) * CW'(size_wr);
            mli_ff <= '0;
            vli_ff <= '0;
         end
         if (csr_we && csr_index == REG_ITERATION_COUNT) begin
            iters_ff <= csr_wdata[ITER_W-1:0];
         end

         // result register: load on finish, clear on transfer
         if (state_ff == ST_FINISH && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_xfer && req_if.cmd == CMD_LOAD_MATRIX) begin
                  if (CW'(mli_ff) + CW'(1) >= nsq_ff) begin
                     mli_ff <= '0;
                  end else begin
                     mli_ff <= mli_ff + MAW'(1);
                  end
               end
               if (req_xfer && req_if.cmd == CMD_LOAD_VECTOR) begin
                  if (CNTW'(vli_ff) + CNTW'(1) >= n_cnt) begin
                     vli_ff <= '0;
                  end else begin
                     vli_ff <= vli_ff + VAW'(1);
                  end
               end
               if (req_xfer && req_if.cmd == CMD_RUN) begin
                  mli_ff  <= '0;
                  vli_ff  <= '0;
                  j_ff    <= '0;
                  sum_ff  <= '0;
                  iter_ff <= '0;
                  sat_ff  <= 1'b0;
               end
            end
            ST_SQ_ACC: begin
               if (sum_wide[64]) begin
                  sum_ff <= '1;
                  sat_ff <= 1'b1;
               end else begin
                  sum_ff <= sum_wide[63:0];
               end
               j_ff <= last_j ? '0 : j_ff + CNTW'(1);
            end
            ST_ROOT_WAIT: begin
               if (sqrt_done) begin
                  nrm_ff <= root;
                  j_ff   <= '0;
                  if (root == '0) begin
                     res_radius_ff <= '0;
                     res_status_ff <= STATUS_ZERO_VEC;
                  end else begin
                     res_radius_ff <= root;
                     res_status_ff <= sat_ff ? STATUS_SATURATED : STATUS_OK;
                  end
               end
            end
            ST_DV_GO: neg_ff <= vec_rd_ff[31];
            ST_DV_WAIT: begin
               if (div_done) begin
                  if (last_j) begin
                     j_ff     <= '0;
                     i_ff     <= '0;
                     maddr_ff <= '0;
                     acc_ff   <= '0;
                  end else begin
                     j_ff <= j_ff + CNTW'(1);
                  end
               end
            end
            ST_MV_ACC: begin
               acc_ff   <= acc_ff + product;
               maddr_ff <= maddr_ff + MAW'(1);
               j_ff     <= last_j ? '0 : j_ff + CNTW'(1);
            end
            ST_MV_WR: begin
               if (!row_fit) begin
                  sat_ff <= 1'b1;
               end
               acc_ff <= '0;
               i_ff   <= i_ff + CNTW'(1);
            end
            ST_CP_WR: begin
               if (last_j) begin
                  j_ff    <= '0;
                  sum_ff  <= '0;
                  iter_ff <= iter_ff + ITER_W'(1);
               end else begin
                  j_ff <= j_ff + CNTW'(1);
               end
            end
            ST_FINISH: begin
               if (out_free) begin
                  rsp_radius_ff <= res_radius_ff;
                  rsp_status_ff <= res_status_ff;
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_if.valid  = rsp_valid_ff;
   assign rsp_if.radius = rsp_radius_ff;
   assign rsp_if.status = rsp_status_ff;
endmodule

/* design/pis_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pis_checker
// port-level checks of the power iteration spectral radius block
// ----------------------------------------------------------------------------
module pis_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [1:0]  req_cmd,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_radius,
   input logic [1:0]  rsp_status
);
   import pis_pkg::*;

   // a pending result stays until transferred
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before transfer");

   // a run transfer makes the block busy
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_cmd == CMD_RUN |=> !req_ready)
      else $error("ready after run transfer");

   // loads and unused commands never create a result
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_cmd != CMD_RUN && !rsp_valid |=> !rsp_valid)
      else $error("result without a run");

   // zero vector result carries zero radius, no unknown status
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status != STATUS_ZERO_VEC || rsp_radius == '0)
                    && rsp_status <= STATUS_ZERO_VEC)
      else $error("bad result status or radius");
endmodule

bind power_iteration_spectral_radius pis_checker u_pis_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_if.valid),
   .req_ready  (req_if.ready),
   .req_cmd    (req_if.cmd),
   .rsp_valid  (rsp_if.valid),
   .rsp_ready  (rsp_if.ready),
   .rsp_radius (rsp_if.radius),
   .rsp_status (rsp_if.status)
);

/* sim/power_iteration_spectral_radius_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// power_iteration_spectral_radius_tb
// self-checking bench for the power method spectral radius estimator
// ----------------------------------------------------------------------------
// loads matrices and start vectors at several sizes and pass counts, runs the
// power method and compares every radius estimate and status with a fixed
// point model kept in a small scoreboard class
// directed items cover the value extremes, norm saturation, row clamping,
// the zero vector, zero passes, register clamping and the unused command
// random items use small sizes; one run takes the norm of a full 64-element
// vector and one runs two passes over a 16x16 matrix
// stores are always filled for the size in use before any run reads them
// ----------------------------------------------------------------------------
module power_iteration_spectral_radius_tb;
   import pis_pkg::*;

   localparam int WATCHDOG_LIMIT = 100000;
   localparam int DRAIN_CYCLES   = 20;
   localparam int RANDOM_ITEMS   = 870;

   typedef struct {
      logic [DATA_W-1:0]   radius;
      logic [STATUS_W-1:0] status;
   } estimate_type;

   // fixed point model of the block plus the queue of pending estimates
   class radius_scoreboard;
      int              matrix_mem[MAX_SIZE_DEFAULT*MAX_SIZE_DEFAULT];
      int              vector_mem[MAX_SIZE_DEFAULT];
      int unsigned     size_in_use;
      int unsigned     pass_count;
      int unsigned     matrix_ptr;
      int unsigned     vector_ptr;
      bit              run_saturated;
      estimate_type    pending[$];
      int              mismatches;

      function new();
         size_in_use = SIZE_RESET;
         pass_count  = ITER_RESET;
         matrix_ptr  = 0;
         vector_ptr  = 0;
         mismatches  = 0;
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         int unsigned s;
         if (idx == REG_SIZE_IN_USE) begin
            s = data[6:0];
            if (s < 1) s = 1;
            if (s > MAX_SIZE_DEFAULT) s = MAX_SIZE_DEFAULT;
            size_in_use = s;
            matrix_ptr  = 0;
            vector_ptr  = 0;
         end else begin
            pass_count = data;
         end
      endfunction

      function logic [31:0] floor_sqrt(logic [63:0] v);
         logic [63:0] root;
         logic [63:0] probe;
         root  = 0;
         probe = 64'd1 << 62;
         while (probe > v) probe = probe >> 2;
         while (probe != 0) begin
            if (v >= root + probe) begin
               v    = v - (root + probe);
               root = (root >> 1) + probe;
            end else begin
               root = root >> 1;
            end
            probe = probe >> 2;
         end
         return root[31:0];
      endfunction

      // sum of squares saturates at all ones
      function logic [31:0] vector_norm();
         logic [63:0] acc;
         logic [63:0] mag;
         logic [63:0] sq;
         longint      e;
         acc = 0;
         for (int i = 0; i < size_in_use; i++) begin
            e   = vector_mem[i];
            mag = (e < 0) ? -e : e;
            sq  = mag * mag;
            if (acc > ~64'd0 - sq) begin
               acc = ~64'd0;
               run_saturated = 1;
            end else begin
               acc = acc + sq;
            end
         end
         return floor_sqrt(acc);
      endfunction

      function void matrix_times_vector();
         int     row_out[MAX_SIZE_DEFAULT];
         longint acc;
         longint p;
         for (int i = 0; i < size_in_use; i++) begin
            acc = 0;
            for (int j = 0; j < size_in_use; j++)
               acc += longint'(matrix_mem[i*size_in_use+j]) * longint'(vector_mem[j]);
            p = acc / 65536;
            if (p > 64'sd2147483647) begin
               p = 64'sd2147483647;
               run_saturated = 1;
            end else if (p < -64'sd2147483648) begin
               p = -64'sd2147483648;
               run_saturated = 1;
            end
            row_out[i] = int'(p);
         end
         for (int i = 0; i < size_in_use; i++) vector_mem[i] = row_out[i];
      endfunction

      function estimate_type run_power_method();
         estimate_type est;
         logic [31:0]  nrm;
         run_saturated = 0;
         matrix_ptr = 0;
         vector_ptr = 0;
         est.radius = 0;
         est.status = STATUS_ZERO_VEC;
         for (int unsigned it = 0; it < pass_count; it++) begin
            nrm = vector_norm();
            if (nrm == 0) return est;
            for (int j = 0; j < size_in_use; j++)
               vector_mem[j] = int'((longint'(vector_mem[j]) * 65536) / longint'(nrm));
            matrix_times_vector();
         end
         nrm = vector_norm();
         if (nrm == 0) return est;
         est.radius = nrm;
         est.status = run_saturated ? STATUS_SATURATED : STATUS_OK;
         return est;
      endfunction

      function void note_transfer(logic [CMD_W-1:0] cmd, logic signed [31:0] value);
         case (cmd)
            CMD_LOAD_MATRIX: begin
               matrix_mem[matrix_ptr] = value;
               matrix_ptr++;
               if (matrix_ptr >= size_in_use * size_in_use) matrix_ptr = 0;
            end
            CMD_LOAD_VECTOR: begin
               vector_mem[vector_ptr] = value;
               vector_ptr++;
               if (vector_ptr >= size_in_use) vector_ptr = 0;
            end
            CMD_RUN: pending.push_back(run_power_method());
            default: ;
         endcase
      endfunction

      function void check_estimate(logic [31:0] radius, logic [1:0] status);
         estimate_type est;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected estimate radius %h status %0d", radius, status);
            return;
         end
         est = pending.pop_front();
         if (radius !== est.radius || status !== est.status) begin
            mismatches++;
            if (mismatches <= 10)
               $display("estimate mismatch: expected radius %h status %0d, got %h %0d",
                        est.radius, est.status, radius, status);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   pis_req_if req ();
   pis_rsp_if rsp ();

   radius_scoreboard sb;
   int send_idle_pct;
   int recv_idle_pct;
   int issued;
   int quiet_cycles;

   power_iteration_spectral_radius u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req),
      .rsp_if    (rsp),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial clock = 0;
   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // receiver backpressure, one decision per cycle
   always @(negedge clock) begin
      rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // transfer monitor and watchdog on the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req.valid && req.ready) sb.note_transfer(req.cmd, req.value);
         if (rsp.valid && rsp.ready) sb.check_estimate(rsp.radius, rsp.status);
         if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || csr_we)
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles > WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   // called at a falling edge, returns at the falling edge after the transfer
   task automatic send(logic [CMD_W-1:0] cmd, logic [31:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 0;
         @(negedge clock);
      end
      req.valid <= 1;
      req.cmd   <= cmd;
      req.value <= value;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      @(negedge clock);
      if (cmd != CMD_UNUSED) issued++;
   endtask

   // drop valid, wait for every estimate, then let the block settle
   task automatic drain();
      req.valid <= 0;
      @(negedge clock);
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      drain();
      csr_we    <= 1;
      csr_index <= idx;
      csr_wdata <= data;
      sb.write_register(idx, data);
      @(negedge clock);
      csr_we <= 0;
      @(negedge clock);
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(3))
         0: return $urandom;
         1: return $urandom_range(32'h0006_0000) - 32'h0003_0000;
         2: return $urandom_range(32'h0000_0100) - 32'h0000_0080;
         default: return $urandom;
      endcase
   endfunction

   // fill both stores for the size in use
   task automatic load_all();
      for (int i = 0; i < sb.size_in_use * sb.size_in_use; i++)
         send(CMD_LOAD_MATRIX, pick_value());
      for (int i = 0; i < sb.size_in_use; i++)
         send(CMD_LOAD_VECTOR, pick_value());
   endtask

   initial begin
      sb = new();
      send_idle_pct = 20;
      recv_idle_pct = 66;
      issued = 0;
      quiet_cycles = 0;
      reset = 1;
      csr_we = 0;
      csr_index = REG_SIZE_IN_USE;
      csr_wdata = 0;
      req.valid = 0;
      req.cmd = CMD_LOAD_MATRIX;
      req.value = 0;
      rsp.ready = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // single element, no passes: norm of the most negative value
      write_csr(REG_SIZE_IN_USE, 16'd1);
      write_csr(REG_ITERATION_COUNT, 16'd0);
      send(CMD_LOAD_MATRIX, 32'h7FFF_FFFF);
      send(CMD_LOAD_VECTOR, 32'h8000_0000);
      send(CMD_RUN, 32'hFFFF_FFFF);
      send(CMD_UNUSED, 32'h1234_5678);
      send(CMD_RUN, 32'h0);
      // zero vector stops the first pass
      write_csr(REG_ITERATION_COUNT, 16'd3);
      send(CMD_LOAD_VECTOR, 32'h0);
      send(CMD_RUN, 32'h0);
      send(CMD_LOAD_MATRIX, 32'h8000_0000);
      send(CMD_LOAD_VECTOR, 32'h0001_0000);
      send(CMD_RUN, 32'h0);
      // raw size above the field width, row sums clamp
      write_csr(REG_SIZE_IN_USE, 16'h0082);
      repeat (4) send(CMD_LOAD_MATRIX, 32'h7FFF_FFFF);
      repeat (2) send(CMD_LOAD_VECTOR, 32'h0000_0001);
      send(CMD_RUN, 32'h0);
      // sum of squares saturates
      write_csr(REG_SIZE_IN_USE, 16'd4);
      write_csr(REG_ITERATION_COUNT, 16'd0);
      repeat (16) send(CMD_LOAD_MATRIX, 32'h0);
      repeat (4) send(CMD_LOAD_VECTOR, 32'h8000_0000);
      send(CMD_RUN, 32'h0);
      // most passes, but the zero vector ends it at once
      write_csr(REG_ITERATION_COUNT, 16'hFFFF);
      repeat (4) send(CMD_LOAD_VECTOR, 32'h0);
      send(CMD_RUN, 32'h0);
      // size zero clamps to one
      write_csr(REG_SIZE_IN_USE, 16'd0);
      write_csr(REG_ITERATION_COUNT, 16'd2);
      send(CMD_LOAD_MATRIX, 32'hFFFE_0000);
      send(CMD_LOAD_VECTOR, 32'h0003_0000);
      send(CMD_RUN, 32'h0);

      // size clamps to the maximum, norm of the full vector, no idling
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_csr(REG_SIZE_IN_USE, 16'h007F);
      write_csr(REG_ITERATION_COUNT, 16'd0);
      for (int i = 0; i < sb.size_in_use; i++)
         send(CMD_LOAD_VECTOR, pick_value());
      send(CMD_RUN, 32'h0);
      // mid size, two passes
      write_csr(REG_SIZE_IN_USE, 16'd16);
      write_csr(REG_ITERATION_COUNT, 16'd2);
      load_all();
      send(CMD_RUN, 32'h0);

      issued = 0;
      for (int mode = 0; mode < 3; mode++) begin
         send_idle_pct = (mode == 0) ? 20 : (mode == 1) ? 66 : 0;
         recv_idle_pct = (mode == 0) ? 66 : (mode == 1) ? 20 : 0;
         while (issued < (mode + 1) * RANDOM_ITEMS / 3) begin
            write_csr(REG_SIZE_IN_USE, 16'($urandom_range(0, 6)));
            write_csr(REG_ITERATION_COUNT, 16'($urandom_range(0, 6)));
            load_all();
            repeat ($urandom_range(3, 8)) begin
               repeat ($urandom_range(0, 4)) begin
                  if ($urandom_range(9) == 0)
                     send(CMD_UNUSED, $urandom);
                  else
                     send(2'($urandom_range(1)), pick_value());
               end
               send(CMD_RUN, $urandom);
            end
         end
      end

      drain();
      if (sb.mismatches == 0 && sb.pending.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

/* power_iteration_spectral_radius.f */
design/pis_pkg.sv
design/pis_if.sv
design/pis_mul.sv
design/pis_div.sv
design/pis_sqrt.sv
design/power_iteration_spectral_radius.sv
design/pis_checker.sv
sim/power_iteration_spectral_radius_tb.sv
